[hdl/ordered_list_cursor_shuffle_top_assert.svh]
// Assertion macros for the ordered key list block.
// Used by ordered_list_cursor_shuffle_top; depends on nothing else.
`ifndef ORDERED_LIST_CURSOR_SHUFFLE_TOP_ASSERT_SVH
`define ORDERED_LIST_CURSOR_SHUFFLE_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define OLCS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that implies a consequence in the following cycle.
`define OLCS_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[hdl/olcs_pkg.sv]
// Package for the ordered key list block: request codes, state codes, constants.
// Used by ordered_list_cursor_shuffle_top; depends on nothing.
`timescale 1ns / 1ps

package olcs_pkg;

   localparam int ENTRIES_DEF  = 64;
   localparam int KEY_BITS_DEF = 32;

   localparam logic [31:0] SEED_XOR = 32'hDEADBEEF;
   localparam logic [31:0] LCG_MUL  = 32'd1664525;
   localparam logic [31:0] LCG_ADD  = 32'd1013904223;

   localparam logic [3:0] REQ_ADD     = 4'd0;
   localparam logic [3:0] REQ_REMOVE  = 4'd1;
   localparam logic [3:0] REQ_CLEAR   = 4'd2;
   localparam logic [3:0] REQ_UP      = 4'd3;
   localparam logic [3:0] REQ_DOWN    = 4'd4;
   localparam logic [3:0] REQ_READ    = 4'd5;
   localparam logic [3:0] REQ_CURRENT = 4'd6;
   localparam logic [3:0] REQ_NEXT    = 4'd7;
   localparam logic [3:0] REQ_PREV    = 4'd8;
   localparam logic [3:0] REQ_SELECT  = 4'd9;
   localparam logic [3:0] REQ_SHUFFLE = 4'd10;

   localparam logic [1:0] CSR_REPEAT = 2'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,     // read entries one by one and compare with the key
      ST_SHIFT,    // copy entry i+1 to i for remove
      ST_SWAP_RD,  // read the second entry of a swap
      ST_SWAP_WR,  // write the saved first entry into the partner slot
      ST_READ,     // wait for one memory read
      ST_LCG,      // advance the generator
      ST_MOD,      // bit-serial remainder
      ST_RESP      // result waits to be taken
   } state_type;

endpackage

[hdl/ordered_list_cursor_shuffle_top.sv]
// Ordered key list with cursor and seeded shuffle: top level and only module.
// Depends on olcs_pkg and ordered_list_cursor_shuffle_top_assert.svh.
`timescale 1ns / 1ps

// The block keeps up to ENTRIES unique keys in one single-port memory and takes
// one item at a time; the result is held on rsp_ until taken. The memory port
// makes one access per cycle. Clear, next, prev and shuffle on fewer than two
// entries go straight to the result; read and current do one memory read; add
// and select scan the list; remove shifts the later entries down; up and down
// swap two entries; shuffle runs for each of the count-1 steps a generator step,
// a bit-serial remainder and, where the partner differs, a two-entry swap.
// No clearing pass is needed after reset.
module ordered_list_cursor_shuffle_top
   import olcs_pkg::*;
#(
   parameter int ENTRIES  = ENTRIES_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_type,
   input  logic [31:0] req_entry_key,
   input  logic [7:0]  req_position,
   input  logic [31:0] req_shuffle_seed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic [31:0] rsp_key_out,
   output logic [5:0]  rsp_cursor_out,
   output logic [6:0]  rsp_count_out,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

`include "ordered_list_cursor_shuffle_top_assert.svh"

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int PW = (CW + 1 > 9) ? CW + 1 : 9;
   localparam logic [CW-1:0] FULL = CW'(ENTRIES);

   // Key memory, one read or write port, registered read data.
   logic [KEY_BITS-1:0] mem [ENTRIES];
   logic [KEY_BITS-1:0] rdata_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_addr;
   logic [KEY_BITS-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_addr];
   end

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       cursor_ff, cursor_in;
   logic [31:0]         lcg_ff, lcg_in;
   logic                repeat_ff;
   logic [3:0]          op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [CW-1:0]       idx_ff, idx_in;    // walking index
   logic [CW-1:0]       jdx_ff, jdx_in;    // swap partner
   logic [KEY_BITS-1:0] tmp_ff, tmp_in;    // first entry of a swap
   logic [32:0]         rem_ff, rem_in;    // remainder in progress
   logic [5:0]          bit_ff, bit_in;
   logic                ok_ff, ok_in;
   logic [31:0]         kout_ff, kout_in;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_REPEAT) begin
         repeat_ff <= csr_pwdata[0];
      end
   end
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_REPEAT) ? {31'd0, repeat_ff} : 32'd0;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_RESP);
   assign rsp_ok         = ok_ff;
   assign rsp_key_out    = kout_ff;
   assign rsp_cursor_out = 6'(cursor_ff);
   assign rsp_count_out  = 7'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
         lcg_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         lcg_ff    <= lcg_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      jdx_ff  <= jdx_in;
      tmp_ff  <= tmp_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
      ok_ff   <= ok_in;
      kout_ff <= kout_in;
   end

   logic [PW-1:0] pos_w;
   logic [CW-1:0] cur_w;
   logic [32:0]   rem_sh;
   logic [32:0]   modulus;

   // Sequencer: next state, memory access and result.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cursor_in = cursor_ff;
      lcg_in    = lcg_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      jdx_in    = jdx_ff;
      tmp_in    = tmp_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      ok_in     = ok_ff;
      kout_in   = kout_ff;
      mem_we    = 1'b0;
      mem_addr  = AW'(idx_ff);
      mem_wdata = rdata_ff;
      pos_w     = PW'(req_position);
      cur_w     = CW'(cursor_ff);
      modulus   = 33'(idx_ff) + 33'd1;
      rem_sh    = {rem_ff[31:0], lcg_ff[5'(bit_ff)]};

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_type;
               key_in  = KEY_BITS'(req_entry_key);
               ok_in   = 1'b0;
               kout_in = '0;
               idx_in  = '0;
               state_in = ST_RESP;
               case (req_type)
                  REQ_ADD, REQ_SELECT: begin
                     if (req_type == REQ_ADD && count_ff == FULL) begin
                        state_in = ST_RESP;
                     end else if (count_ff == '0) begin
                        if (req_type == REQ_ADD) begin
                           mem_we    = 1'b1;
                           mem_addr  = '0;
                           mem_wdata = KEY_BITS'(req_entry_key);
                           count_in  = count_ff + 1'b1;
                           ok_in     = 1'b1;
                        end
                     end else begin
                        mem_addr = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_REMOVE: begin
                     if (pos_w < PW'(count_ff)) begin
                        ok_in  = 1'b1;
                        idx_in = CW'(req_position);
                        bit_in = 6'd0;
                        count_in = count_ff - 1'b1;
                        if (count_ff == CW'(1)) begin
                           cursor_in = '0;
                        end else if (cur_w >= count_ff - 1'b1) begin
                           cursor_in = AW'(count_ff - CW'(2));
                        end else if (CW'(req_position) < cur_w) begin
                           cursor_in = cursor_ff - 1'b1;
                        end
                        if (pos_w + 1 < PW'(count_ff)) begin
                           mem_addr = AW'(pos_w + 1);
                           state_in = ST_SHIFT;
                        end
                     end
                  end
                  REQ_CLEAR: begin
                     count_in  = '0;
                     cursor_in = '0;
                     ok_in     = 1'b1;
                  end
                  REQ_UP, REQ_DOWN: begin
                     if (req_type == REQ_UP ? (pos_w != '0 && pos_w < PW'(count_ff))
                                            : (pos_w + 1 < PW'(count_ff))) begin
                        ok_in  = 1'b1;
                        idx_in = (req_type == REQ_UP) ? CW'(pos_w - 1) : CW'(pos_w);
                        jdx_in = CW'(idx_in + 1'b1);
                        mem_addr = AW'(idx_in);
                        state_in = ST_SWAP_RD;
                        if (cur_w == idx_in) begin
                           cursor_in = AW'(idx_in + 1'b1);
                        end else if (cur_w == idx_in + 1'b1) begin
                           cursor_in = AW'(idx_in);
                        end
                     end
                  end
                  REQ_READ: begin
                     if (pos_w < PW'(count_ff)) begin
                        mem_addr = AW'(pos_w);
                        state_in = ST_READ;
                     end
                  end
                  REQ_CURRENT: begin
                     if (count_ff != '0) begin
                        mem_addr = cursor_ff;
                        state_in = ST_READ;
                     end
                  end
                  REQ_NEXT: begin
                     if (count_ff != '0) begin
                        if (cur_w + 1'b1 < count_ff) begin
                           cursor_in = cursor_ff + 1'b1;
                           ok_in = 1'b1;
                        end else if (repeat_ff) begin
                           cursor_in = '0;
                           ok_in = 1'b1;
                        end
                     end
                  end
                  REQ_PREV: begin
                     if (count_ff != '0) begin
                        if (cursor_ff != '0) begin
                           cursor_in = cursor_ff - 1'b1;
                           ok_in = 1'b1;
                        end else if (repeat_ff) begin
                           cursor_in = AW'(count_ff - 1'b1);
                           ok_in = 1'b1;
                        end
                     end
                  end
                  REQ_SHUFFLE: begin
                     ok_in = 1'b1;
                     if (count_ff >= CW'(2)) begin
                        lcg_in    = req_shuffle_seed ^ SEED_XOR;
                        idx_in    = count_ff - 1'b1;
                        cursor_in = '0;
                        state_in  = ST_LCG;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // rdata holds entry idx.
            if (rdata_ff == key_ff) begin
               if (op_ff == REQ_SELECT) begin
                  cursor_in = AW'(idx_ff);
                  ok_in = 1'b1;
               end
               state_in = ST_RESP;
            end else if (idx_ff + 1'b1 == count_ff) begin
               if (op_ff == REQ_ADD) begin
                  mem_we    = 1'b1;
                  mem_addr  = AW'(count_ff);
                  mem_wdata = key_ff;
                  count_in  = count_ff + 1'b1;
                  ok_in     = 1'b1;
               end
               state_in = ST_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               mem_addr = AW'(idx_ff + 1'b1);
            end
         end
         ST_SHIFT: begin
            // rdata holds entry idx+1; write it to idx, then read the next one.
            if (bit_ff[0] == 1'b0) begin
               mem_we   = 1'b1;
               mem_addr = AW'(idx_ff);
               idx_in   = idx_ff + 1'b1;
               bit_in   = 6'd1;
               if (idx_ff + 1'b1 >= count_ff) begin
                  state_in = ST_RESP;
                  bit_in   = 6'd0;
               end
            end else begin
               mem_addr = AW'(idx_ff + 1'b1);
               bit_in   = 6'd0;
            end
         end
         ST_SWAP_RD: begin
            // rdata holds entry idx; read jdx next.
            tmp_in   = rdata_ff;
            mem_addr = AW'(jdx_ff);
            state_in = ST_READ;
            bit_in   = 6'd0;
         end
         ST_READ: begin
            if (op_ff == REQ_READ || op_ff == REQ_CURRENT) begin
               kout_in  = 32'(rdata_ff);
               ok_in    = 1'b1;
               state_in = ST_RESP;
            end else begin
               // Swap: write entry jdx into idx.
               mem_we    = 1'b1;
               mem_addr  = AW'(idx_ff);
               mem_wdata = rdata_ff;
               state_in  = ST_SWAP_WR;
            end
         end
         ST_SWAP_WR: begin
            mem_we    = 1'b1;
            mem_addr  = AW'(jdx_ff);
            mem_wdata = tmp_ff;
            if (op_ff == REQ_SHUFFLE && idx_ff > CW'(1)) begin
               idx_in   = idx_ff - 1'b1;
               state_in = ST_LCG;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_LCG: begin
            lcg_in   = lcg_ff * LCG_MUL + LCG_ADD;
            rem_in   = '0;
            bit_in   = 6'd31;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            // Restoring remainder, one dividend bit a cycle, msb first.
            rem_in = (rem_sh >= modulus) ? rem_sh - modulus : rem_sh;
            bit_in = bit_ff - 1'b1;
            if (bit_ff == 6'd0) begin
               jdx_in = CW'(rem_in);
               if (CW'(rem_in) != idx_ff) begin
                  mem_addr = AW'(idx_ff);
                  state_in = ST_SWAP_RD;
               end else if (idx_ff > CW'(1)) begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = ST_LCG;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `OLCS_ASSERT(a_count_range, count_ff <= FULL, "entry count above capacity")
   `OLCS_ASSERT(a_cursor_range, count_ff == '0 || CW'(cursor_ff) < count_ff,
      "cursor past the last entry")
   `OLCS_ASSERT_NEXT(a_resp_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_key_out),
      "stalled result changed")
   `OLCS_ASSERT_NEXT(a_busy_no_accept, state_ff != ST_IDLE && state_ff != ST_RESP,
      !rsp_valid || $past(state_ff) != ST_IDLE, "result without work")

endmodule

[bench/tb_ordered_list_cursor_shuffle_top.sv]
// Self-checking bench for the ordered key list block with cursor and shuffle.
// Depends on olcs_pkg and ordered_list_cursor_shuffle_top; drives random and directed items.
`timescale 1ns / 1ps

// Keeps a model of the key list and the queue of results it predicts.
class list_scoreboard;
   bit [31:0] keys[64];
   int unsigned count;
   int unsigned cursor;
   bit [31:0] lcg;
   bit repeat_en;
   bit [45:0] pending[$];
   int errors;

   function bit find(bit [31:0] k, output int unsigned where);
      for (int unsigned i = 0; i < count; i++)
         if (keys[i] == k) begin
            where = i;
            return 1;
         end
      return 0;
   endfunction

   function void swap(int unsigned a, int unsigned b);
      bit [31:0] t;
      t = keys[a];
      keys[a] = keys[b];
      keys[b] = t;
   endfunction

   // Applies one accepted item to the model and queues its result.
   function void note_item(bit [3:0] op, bit [31:0] k, bit [7:0] pos, bit [31:0] seed);
      bit ok;
      bit [31:0] kout;
      int unsigned j;
      bit [31:0] s;
      ok = 0;
      kout = 0;
      case (op)
         olcs_pkg::REQ_ADD:
            if (count < 64 && !find(k, j)) begin
               keys[count] = k;
               count++;
               ok = 1;
            end
         olcs_pkg::REQ_REMOVE:
            if (pos < count) begin
               for (int unsigned i = pos; i + 1 < count; i++) keys[i] = keys[i + 1];
               count--;
               if (count == 0) cursor = 0;
               else if (cursor >= count) cursor = count - 1;
               else if (pos < cursor) cursor--;
               ok = 1;
            end
         olcs_pkg::REQ_CLEAR: begin
            count = 0;
            cursor = 0;
            ok = 1;
         end
         olcs_pkg::REQ_UP:
            if (pos != 0 && pos < count) begin
               swap(pos - 1, pos);
               if (cursor == pos) cursor = pos - 1;
               else if (cursor == pos - 1) cursor = pos;
               ok = 1;
            end
         olcs_pkg::REQ_DOWN:
            if (pos + 1 < count) begin
               swap(pos, pos + 1);
               if (cursor == pos) cursor = pos + 1;
               else if (cursor == pos + 1) cursor = pos;
               ok = 1;
            end
         olcs_pkg::REQ_READ:
            if (pos < count) begin
               kout = keys[pos];
               ok = 1;
            end
         olcs_pkg::REQ_CURRENT:
            if (count != 0) begin
               kout = keys[cursor];
               ok = 1;
            end
         olcs_pkg::REQ_NEXT:
            if (count != 0) begin
               if (cursor + 1 < count) begin
                  cursor++;
                  ok = 1;
               end else if (repeat_en) begin
                  cursor = 0;
                  ok = 1;
               end
            end
         olcs_pkg::REQ_PREV:
            if (count != 0) begin
               if (cursor > 0) begin
                  cursor--;
                  ok = 1;
               end else if (repeat_en) begin
                  cursor = count - 1;
                  ok = 1;
               end
            end
         olcs_pkg::REQ_SELECT:
            if (find(k, j)) begin
               cursor = j;
               ok = 1;
            end
         olcs_pkg::REQ_SHUFFLE: begin
            ok = 1;
            if (count >= 2) begin
               s = seed ^ olcs_pkg::SEED_XOR;
               for (int unsigned i = count - 1; i > 0; i--) begin
                  s = s * olcs_pkg::LCG_MUL + olcs_pkg::LCG_ADD;
                  j = s % (i + 1);
                  if (i != j) swap(i, j);
               end
               lcg = s;
               cursor = 0;
            end
         end
         default: ;
      endcase
      pending.push_back({ok, kout, 6'(cursor), 7'(count)});
   endfunction

   // Compares one accepted result with the oldest prediction.
   function void check_result(bit ok, bit [31:0] kout, bit [5:0] cur, bit [6:0] cnt);
      bit [45:0] want;
      bit [45:0] got;
      if (pending.size() == 0) begin
         $display("%0t: result with nothing predicted ok=%0d key=%h cur=%0d cnt=%0d",
                  $time, ok, kout, cur, cnt);
         errors++;
         return;
      end
      want = pending.pop_front();
      got = {ok, kout, cur, cnt};
      if (want !== got) begin
         $display("%0t: mismatch expected ok=%0d key=%h cur=%0d cnt=%0d", $time,
                  want[45], want[44:13], want[12:7], want[6:0]);
         $display("%0t:          actual   ok=%0d key=%h cur=%0d cnt=%0d", $time,
                  ok, kout, cur, cnt);
         errors++;
      end
   endfunction
endclass

module tb_ordered_list_cursor_shuffle_top;
   import olcs_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [3:0]  req_type = 0;
   logic [31:0] req_entry_key = 0;
   logic [7:0]  req_position = 0;
   logic [31:0] req_shuffle_seed = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_ok;
   logic [31:0] rsp_key_out;
   logic [5:0]  rsp_cursor_out;
   logic [6:0]  rsp_count_out;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [1:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   list_scoreboard board;
   bit calm;
   bit [31:0] used_keys[$];

   ordered_list_cursor_shuffle_top u_dut (.*);

   always #4 clock = ~clock;

   // The result side stalls at random except during the calm stretch.
   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 31);

   // Results are taken at the rising edge when valid and not stalled.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_ok, rsp_key_out, rsp_cursor_out, rsp_count_out);

   // Writes the repeat register through the bus setup and access phases.
   task automatic write_repeat(bit v);
      @(negedge clock);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= CSR_REPEAT;
      csr_pwdata <= {31'd0, v};
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      board.repeat_en = v;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   // Waits for every predicted result.
   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Presents one item and holds it until accepted.
   task automatic send(bit [3:0] op, bit [31:0] k, bit [7:0] pos, bit [31:0] seed);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 31) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_type <= op;
      req_entry_key <= k;
      req_position <= pos;
      req_shuffle_seed <= seed;
      do @(posedge clock); while (req_stall);
      board.note_item(op, k, pos, seed);
      @(negedge clock);
      req_valid <= 0;
   endtask

   // Picks a key that is often already in the list.
   function automatic bit [31:0] pick_key();
      if (used_keys.size() != 0 && $urandom_range(1))
         return used_keys[$urandom_range(used_keys.size() - 1)];
      pick_key = $urandom();
      used_keys.push_back(pick_key);
      if (used_keys.size() > 200) void'(used_keys.pop_front());
   endfunction

   // Random item biased toward positions inside the list.
   task automatic random_item();
      bit [3:0] op;
      bit [7:0] pos;
      int r;
      r = $urandom_range(99);
      if (r < 2) op = 4'($urandom_range(11, 15));
      else if (r < 30) op = REQ_ADD;
      else if (r < 31) op = REQ_CLEAR;
      else op = 4'($urandom_range(0, 10));
      if (op == REQ_CLEAR && board.count > 4 && $urandom_range(3) != 0) op = REQ_SELECT;
      if ($urandom_range(9) == 0) pos = 8'($urandom());
      else pos = 8'($urandom_range(board.count + 1));
      if (op == REQ_SHUFFLE && board.count > 16 && $urandom_range(3) != 0) op = REQ_READ;
      send(op, pick_key(), pos, $urandom());
   endtask

   initial begin
      board = new();
      calm = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      write_repeat(0);

      // Directed part: empty list cases, key extremes, every request.
      send(REQ_CURRENT, 0, 0, 0);
      send(REQ_NEXT, 0, 0, 0);
      send(REQ_SHUFFLE, 0, 0, 32'hFFFFFFFF);
      send(REQ_ADD, 32'h0, 0, 0);
      send(REQ_SHUFFLE, 0, 0, 1);
      send(REQ_ADD, 32'hFFFFFFFF, 0, 0);
      send(REQ_ADD, 32'h0, 0, 0);
      send(REQ_ADD, 32'h5A5AA5A5, 0, 0);
      send(REQ_PREV, 0, 0, 0);
      send(REQ_NEXT, 0, 0, 0);
      send(REQ_NEXT, 0, 0, 0);
      send(REQ_NEXT, 0, 0, 0);
      send(REQ_UP, 0, 0, 0);
      send(REQ_UP, 0, 2, 0);
      send(REQ_DOWN, 0, 2, 0);
      send(REQ_DOWN, 0, 0, 0);
      send(REQ_READ, 0, 255, 0);
      send(REQ_READ, 0, 1, 0);
      send(REQ_SELECT, 32'hFFFFFFFF, 0, 0);
      send(REQ_SELECT, 32'h12345678, 0, 0);
      send(REQ_SHUFFLE, 0, 0, 32'hDEADBEEF);
      send(REQ_REMOVE, 0, 0, 0);
      send(REQ_REMOVE, 0, 200, 0);
      send(4'd15, 0, 0, 0);
      send(REQ_CLEAR, 0, 0, 0);
      drain();
      write_repeat(1);

      // Fill the table to the brim and try one more.
      for (int i = 0; i < 65; i++) send(REQ_ADD, 32'h1000 + i, 0, 0);
      send(REQ_PREV, 0, 0, 0);
      send(REQ_NEXT, 0, 0, 0);
      send(REQ_SHUFFLE, 0, 0, $urandom());
      send(REQ_CURRENT, 0, 0, 0);
      send(REQ_REMOVE, 0, 63, 0);

      // Random part in phases with changing wrap setting.
      for (int ph = 0; ph < 4; ph++) begin
         calm = (ph == 2);
         for (int n = 0; n < 260; n++) random_item();
         drain();
         write_repeat(ph[0]);
      end
      calm = 0;
      drain();

      if (board.errors == 0 && board.pending.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end
endmodule

[files.f]
+incdir+hdl
hdl/olcs_pkg.sv
hdl/ordered_list_cursor_shuffle_top.sv
bench/tb_ordered_list_cursor_shuffle_top.sv
